/* sv/bq_pkg.sv */
// ----------------------------------------------------------------------------
// Biquad filter package
// Widths, coefficient register indexes, sequencer states and the control
// bundle shared by the biquad filter modules.
// ----------------------------------------------------------------------------
package bq_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 18;
  localparam int STATE_W    = 40;
  localparam int NUM_COEFS  = 5;
  localparam int CFG_IDX_W  = $clog2(NUM_COEFS);
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int ACC_W      = STATE_W + 2;
  localparam int FRAC_SHIFT = COEF_W - 4;
  localparam int SHR_W      = ACC_W - FRAC_SHIFT;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef coef_t [NUM_COEFS-1:0]      coef_bank_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CS_N0 = CFG_IDX_W'(0),
    CS_N1 = CFG_IDX_W'(1),
    CS_N2 = CFG_IDX_W'(2),
    CS_D1 = CFG_IDX_W'(3),
    CS_D2 = CFG_IDX_W'(4)
  } coef_sel_e;

  localparam coef_bank_t COEF_RESET = '{
    coef_t'(6763), coef_t'(-18727), coef_t'(1105), coef_t'(2212), coef_t'(1105)
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_Y,
    ST_N1,
    ST_D1,
    ST_N2,
    ST_D2
  } st_e;

  typedef struct packed {
    logic      x_load;
    logic      use_in;
    logic      use_y;
    coef_sel_e coef_sel;
    logic      y_load;
    logic      acc_load;
    logic      acc_add_s2;
    logic      s1_load;
    logic      s2_load;
  } ctrl_t;

endpackage

/* sv/bq_if.sv */
// ----------------------------------------------------------------------------
// Biquad filter channel interfaces
// Sample, result and coefficient write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bq_sample_if import bq_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface bq_result_if import bq_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_out;
  logic    clipped;

  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink (input valid, input sample_out, input clipped, output ready);
endinterface

interface bq_cfg_if import bq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  coef_t                data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/bq_coef_regs.sv */
// ----------------------------------------------------------------------------
// Biquad coefficient registers
// Five Q3.14 coefficient registers written through the configuration channel.
// ----------------------------------------------------------------------------
module bq_coef_regs import bq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  logic [CFG_IDX_W-1:0] wr_idx_i,
  input  coef_t                wr_data_i,
  output coef_bank_t           coefs_o
);

  coef_bank_t coefs_q;
  coef_bank_t coefs_d;

  always_comb begin
    coefs_d = coefs_q;
    for (int i = 0; i < NUM_COEFS; i++) begin
      if (wr_en_i && (wr_idx_i == CFG_IDX_W'(i))) begin
        coefs_d[i] = wr_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coefs_q <= COEF_RESET;
    end else begin
      coefs_q <= coefs_d;
    end
  end

  assign coefs_o = coefs_q;

endmodule

/* sv/bq_datapath.sv */
// ----------------------------------------------------------------------------
// Biquad datapath
// Shared multiplier with registered product, accumulator, output rounding
// and saturation, and the two saturating delay states.
// ----------------------------------------------------------------------------
module bq_datapath import bq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_t      ctrl_i,
  input  coef_bank_t coefs_i,
  input  sample_t    sample_in_i,
  output sample_t    sample_out_o,
  output logic       clipped_o
);

  localparam logic signed [ACC_W-1:0] ROUND_ADD = ACC_W'(1) << (FRAC_SHIFT - 1);

  sample_t                    x_q;
  sample_t                    y_q;
  sample_t                    y_d;
  logic                       clip_q;
  logic                       clip_d;
  sample_t                    mul_a;
  coef_t                      mul_b;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [PROD_W-1:0]   prod_d;
  logic signed [ACC_W-1:0]    acc_q;
  logic signed [ACC_W-1:0]    acc_d;
  logic signed [STATE_W-1:0]  s1_q;
  logic signed [STATE_W-1:0]  s2_q;
  logic signed [STATE_W-1:0]  s_sat;
  logic signed [ACC_W-1:0]    y_sum;
  logic        [SHR_W-1:0]    y_shr;
  logic signed [ACC_W-1:0]    s_diff;
  logic                       y_ovf;
  logic                       s_ovf;

  always_comb begin
    if (ctrl_i.use_in) begin
      mul_a = sample_in_i;
    end else if (ctrl_i.use_y) begin
      mul_a = y_q;
    end else begin
      mul_a = x_q;
    end
    case (ctrl_i.coef_sel)
      CS_N0:   mul_b = coefs_i[CS_N0];
      CS_N1:   mul_b = coefs_i[CS_N1];
      CS_N2:   mul_b = coefs_i[CS_N2];
      CS_D1:   mul_b = coefs_i[CS_D1];
      CS_D2:   mul_b = coefs_i[CS_D2];
      default: mul_b = '0;
    endcase
  end

  assign prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign y_sum = ACC_W'(prod_q) + ACC_W'(s1_q) + ROUND_ADD;
  assign y_shr = y_sum[ACC_W-1:FRAC_SHIFT];
  assign y_ovf = !((&y_shr[SHR_W-1:SAMPLE_W-1]) || !(|y_shr[SHR_W-1:SAMPLE_W-1]));

  always_comb begin
    clip_d = y_ovf;
    if (y_ovf) begin
      y_d = {y_shr[SHR_W-1], {(SAMPLE_W-1){~y_shr[SHR_W-1]}}};
    end else begin
      y_d = y_shr[SAMPLE_W-1:0];
    end
  end

  assign s_diff = acc_q - ACC_W'(prod_q);
  assign s_ovf  = !((&s_diff[ACC_W-1:STATE_W-1]) || !(|s_diff[ACC_W-1:STATE_W-1]));

  always_comb begin
    if (s_ovf) begin
      s_sat = {s_diff[ACC_W-1], {(STATE_W-1){~s_diff[ACC_W-1]}}};
    end else begin
      s_sat = s_diff[STATE_W-1:0];
    end
    if (ctrl_i.acc_add_s2) begin
      acc_d = ACC_W'(prod_q) + ACC_W'(s2_q);
    end else begin
      acc_d = ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (ctrl_i.x_load) begin
      x_q <= sample_in_i;
    end
    if (ctrl_i.y_load) begin
      y_q    <= y_d;
      clip_q <= clip_d;
    end
    if (ctrl_i.acc_load) begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else begin
      if (ctrl_i.s1_load) begin
        s1_q <= s_sat;
      end
      if (ctrl_i.s2_load) begin
        s2_q <= s_sat;
      end
    end
  end

  assign sample_out_o = y_q;
  assign clipped_o    = clip_q;

endmodule

/* sv/bq_ctrl.sv */
// ----------------------------------------------------------------------------
// Biquad sequencer
// Steps the shared multiplier through the five products of one sample and
// owns the input ready and the output valid.
// ----------------------------------------------------------------------------
module bq_ctrl import bq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output ctrl_t ctrl_o
);

  st_e   st_q;
  st_e   st_d;
  logic  out_valid_q;
  logic  out_valid_d;
  logic  stall;
  ctrl_t ctrl;

  assign stall = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    st_d        = st_q;
    in_ready_o  = 1'b0;
    out_valid_d = stall;
    ctrl        = '{coef_sel: CS_N0, default: 1'b0};
    case (st_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl.x_load = 1'b1;
          ctrl.use_in = 1'b1;
          st_d        = ST_Y;
        end
      end
      ST_Y: begin
        if (!stall) begin
          ctrl.y_load   = 1'b1;
          ctrl.coef_sel = CS_N1;
          out_valid_d   = 1'b1;
          st_d          = ST_N1;
        end
      end
      ST_N1: begin
        ctrl.acc_load   = 1'b1;
        ctrl.acc_add_s2 = 1'b1;
        ctrl.use_y      = 1'b1;
        ctrl.coef_sel   = CS_D1;
        st_d            = ST_D1;
      end
      ST_D1: begin
        ctrl.s1_load  = 1'b1;
        ctrl.coef_sel = CS_N2;
        st_d          = ST_N2;
      end
      ST_N2: begin
        ctrl.acc_load = 1'b1;
        ctrl.use_y    = 1'b1;
        ctrl.coef_sel = CS_D2;
        st_d          = ST_D2;
      end
      ST_D2: begin
        ctrl.s2_load = 1'b1;
        in_ready_o   = 1'b1;
        if (in_valid_i) begin
          ctrl.x_load = 1'b1;
          ctrl.use_in = 1'b1;
          st_d        = ST_Y;
        end else begin
          st_d = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  assign ctrl_o      = ctrl;
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_accept_to_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> st_q == ST_Y)
    else $error("accepted sample did not start the output step");

  a_y_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_Y && !stall |=> out_valid_q && st_q == ST_N1)
    else $error("output step did not present a result");

  a_state_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_N1 |=> st_q == ST_D1 ##1 st_q == ST_N2 ##1 st_q == ST_D2)
    else $error("state update steps out of order");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_Y || st_q == ST_N1 || st_q == ST_D1 || st_q == ST_N2 |-> !in_ready_o)
    else $error("sample accepted during a state update");
`endif

endmodule

/* sv/biquad_iir_filter_unit.sv */
// ----------------------------------------------------------------------------
// Biquad IIR filter unit
// Second-order IIR filter in transposed direct form II with one shared
// 16x18 multiplier stepped by a small sequencer.
//
//   Channel  Dir  Payload               Notes
//   in_i     in   sample_in  Q1.15      one transaction per sample
//   out_o    out  sample_out Q1.15,     one transaction per sample
//                 clipped
//   cfg_i    in   index, data Q3.14     always ready; unused indexes ignored
//
// After acceptance a sample steps through ST_Y, ST_N1, ST_D1, ST_N2 and ST_D2,
// one product per step on the shared multiplier from acceptance to ST_N2 and
// the last state update in ST_D2; a new sample can be taken alongside it.
// The result is registered in the output step ST_Y from the registered product.
// Reset restores the default coefficients and clears both delay states.
// A result not yet taken holds the sequencer at its output step.
// ----------------------------------------------------------------------------
module biquad_iir_filter_unit import bq_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  bq_sample_if.sink   in_i,
  bq_result_if.source out_o,
  bq_cfg_if.sink      cfg_i
);

  coef_bank_t coefs;
  ctrl_t      ctrl;

  assign cfg_i.ready = 1'b1;

  bq_coef_regs u_coef_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_i.valid),
    .wr_idx_i  (cfg_i.index),
    .wr_data_i (cfg_i.data),
    .coefs_o   (coefs)
  );

  bq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .ctrl_o      (ctrl)
  );

  bq_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .coefs_i      (coefs),
    .sample_in_i  (in_i.sample_in),
    .sample_out_o (out_o.sample_out),
    .clipped_o    (out_o.clipped)
  );

endmodule
